// ----- src/arc_pkg.sv -----
// Shared types and constants for the announcement retry controller.
`timescale 1ns / 1ps

package arc_pkg;

   // Width of the millisecond time fields.
   localparam int TIME_BITS = 48;

   // Configuration register indexes.
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 16;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RETRY_INTERVAL = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_ATTEMPTS   = 1'd1;

   // Reset values of the configuration registers.
   localparam logic [15:0] RETRY_INTERVAL_RESET = 16'd1000;
   localparam logic [7:0]  MAX_ATTEMPTS_RESET   = 8'd3;

   // Answer reported when no transport exists.
   localparam logic [7:0] RESULT_NO_TRANSPORT = 8'hFF;

   // Largest time value; retry times saturate here.
   localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

   // One input transaction.
   typedef struct packed {
      logic [TIME_BITS-1:0] now_ms;
      logic                 link_ready;
      logic                 send_available;
      logic signed [7:0]    send_result;
   } req_type;

   // One result transaction.
   typedef struct packed {
      logic                 attempted;
      logic                 pending;
      logic                 exhausted;
      logic [15:0]          total_attempts;
      logic [7:0]           episode_sends;
      logic [15:0]          failure_count;
      logic [15:0]          acceptance_count;
      logic [15:0]          episode_count;
      logic signed [7:0]    last_send_result;
      logic [TIME_BITS-1:0] first_attempt_time;
      logic [TIME_BITS-1:0] last_attempt_time;
      logic [TIME_BITS-1:0] last_accept_time;
   } rsp_type;

   // Controller state carried from tick to tick.
   typedef struct packed {
      logic                 was_ready;
      logic                 pending;
      logic                 exhausted;
      logic [15:0]          attempt_total;
      logic [7:0]           episode_sends;
      logic [15:0]          failures;
      logic [15:0]          acceptances;
      logic [15:0]          episodes;
      logic [TIME_BITS-1:0] next_due;
      logic [TIME_BITS-1:0] first_time;
      logic [TIME_BITS-1:0] last_time;
      logic [TIME_BITS-1:0] accept_time;
      logic [7:0]           latest_result;
   } state_type;

endpackage

// ----- src/arc_step.sv -----
// Next-state logic for one tick of the announcement retry controller.
`timescale 1ns / 1ps

module arc_step (
   input  arc_pkg::state_type st,
   input  arc_pkg::req_type   req,
   input  logic [15:0]        retry_interval,
   input  logic [7:0]         max_attempts,
   output arc_pkg::state_type st_in,
   output logic               attempted
);

   logic [7:0]                   res;
   logic                         accepted;
   logic [7:0]                   ep_attempts_inc;
   logic [arc_pkg::TIME_BITS:0]  retry_sum;

   // Retry deadline, saturating at the largest time value.
   assign retry_sum = {1'b0, req.now_ms}
                    + {{(arc_pkg::TIME_BITS + 1 - 16){1'b0}}, retry_interval};

   // Answer of a send made on this tick; positive means accepted.
   assign res      = req.send_available ? req.send_result : arc_pkg::RESULT_NO_TRANSPORT;
   assign accepted = (res != 8'd0) && !res[7];

   always_comb begin
      st_in           = st;
      attempted       = 1'b0;
      ep_attempts_inc = 8'd0;
      if (!req.link_ready) begin
         // Link down drops the pending announcement.
         st_in.was_ready = 1'b0;
         st_in.pending   = 1'b0;
      end else begin
         // Rising link starts a new episode, due at once.
         if (!st.was_ready) begin
            st_in.was_ready     = 1'b1;
            st_in.pending       = 1'b1;
            st_in.exhausted     = 1'b0;
            st_in.episode_sends = 8'd0;
            st_in.episodes      = (st.episodes == 16'hFFFF) ? st.episodes
                                                            : st.episodes + 16'd1;
            st_in.next_due      = req.now_ms;
         end
         // Send attempt when pending and due.
         if (st_in.pending && (req.now_ms >= st_in.next_due)) begin
            attempted       = 1'b1;
            ep_attempts_inc = (st_in.episode_sends == 8'hFF) ? st_in.episode_sends
                                                             : st_in.episode_sends + 8'd1;
            if (st.attempt_total == 16'd0) begin
               st_in.first_time = req.now_ms;
            end
            st_in.attempt_total = (st.attempt_total == 16'hFFFF) ? st.attempt_total
                                                                 : st.attempt_total + 16'd1;
            st_in.episode_sends = ep_attempts_inc;
            st_in.last_time     = req.now_ms;
            st_in.latest_result = res;
            if (accepted) begin
               st_in.acceptances = (st.acceptances == 16'hFFFF) ? st.acceptances
                                                                : st.acceptances + 16'd1;
               st_in.accept_time = req.now_ms;
               st_in.pending     = 1'b0;
            end else begin
               st_in.failures = (st.failures == 16'hFFFF) ? st.failures
                                                          : st.failures + 16'd1;
               if (ep_attempts_inc >= max_attempts) begin
                  st_in.pending   = 1'b0;
                  st_in.exhausted = 1'b1;
               end else begin
                  st_in.next_due = retry_sum[arc_pkg::TIME_BITS] ? arc_pkg::TIME_MAX
                                   : retry_sum[arc_pkg::TIME_BITS-1:0];
               end
            end
         end
      end
   end

endmodule

// ----- src/announcement_retry_controller.sv -----
// Top level of the announcement retry controller.
`timescale 1ns / 1ps

// Channel   Ports                               Direction
// req       req_valid, req_ready, req_data      in:  one tick (time, link, send answer)
// rsp       rsp_valid, rsp_ready, rsp_data      out: one result per tick
// csr       csr_wen, csr_index, csr_wdata       in:  register writes, no wait
//
// One transaction per clock is sustained while results are taken; each accepted transaction
// passes the input register, then the next-state logic into the state and result register.
// The 48-bit due-time compare and retry add set the cycle path.
// Reset is synchronous and clears the state and valid flags; retry interval resets to 1000, max attempts to 3.
// A stalled result holds the state; the input register still takes one more transaction.

module announcement_retry_controller (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  arc_pkg::req_type                     req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output arc_pkg::rsp_type                     rsp_data,
   input  logic                                 csr_wen,
   input  logic [arc_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [arc_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   logic               in_valid_ff;
   arc_pkg::req_type   in_data_ff;
   logic               rsp_valid_ff;
   logic               attempted_ff;
   arc_pkg::state_type st_ff;
   arc_pkg::state_type st_in;
   logic               attempted_in;
   logic [15:0]        retry_ff;
   logic [7:0]         max_ff;
   logic               advance;

   // Move the held transaction into the result stage when that stage is free.
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         retry_ff <= arc_pkg::RETRY_INTERVAL_RESET;
         max_ff   <= arc_pkg::MAX_ATTEMPTS_RESET;
      end else if (csr_wen) begin
         unique case (csr_index)
            arc_pkg::CSR_RETRY_INTERVAL: retry_ff <= csr_wdata;
            arc_pkg::CSR_MAX_ATTEMPTS:   max_ff   <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_data_ff <= req_data;
      end
   end

   // Next-state logic.
   arc_step u_step (
      .st             (st_ff),
      .req            (in_data_ff),
      .retry_interval (retry_ff),
      .max_attempts   (max_ff),
      .st_in          (st_in),
      .attempted      (attempted_in)
   );

   // State and result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         attempted_ff <= 1'b0;
         st_ff        <= '0;
      end else begin
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            attempted_ff <= attempted_in;
            st_ff        <= st_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Result fields come straight from the state and result register.
   always_comb begin
      rsp_data.attempted          = attempted_ff;
      rsp_data.pending            = st_ff.pending;
      rsp_data.exhausted          = st_ff.exhausted;
      rsp_data.total_attempts     = st_ff.attempt_total;
      rsp_data.episode_sends      = st_ff.episode_sends;
      rsp_data.failure_count      = st_ff.failures;
      rsp_data.acceptance_count   = st_ff.acceptances;
      rsp_data.episode_count      = st_ff.episodes;
      rsp_data.last_send_result   = st_ff.latest_result;
      rsp_data.first_attempt_time = st_ff.first_time;
      rsp_data.last_attempt_time  = st_ff.last_time;
      rsp_data.last_accept_time   = st_ff.accept_time;
   end

`ifndef NO_ASSERTIONS
   // An episode is never both pending and exhausted.
   a_pending_exhausted: assert property (@(posedge clock) disable iff (reset)
      !(st_ff.pending && st_ff.exhausted))
      else $error("pending and exhausted both set");

   // A reported attempt always counts in its episode.
   a_attempt_counted: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && attempted_ff) |-> (st_ff.episode_sends != 8'd0))
      else $error("attempt without episode count");

   // Acceptances never outnumber attempts.
   a_accept_bound: assert property (@(posedge clock) disable iff (reset)
      st_ff.acceptances <= st_ff.attempt_total)
      else $error("acceptances exceed attempts");

   // A stalled result keeps the state unchanged.
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> $stable(st_ff))
      else $error("state changed under stall");
`endif

endmodule
